/* rtl/bds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types, codes and constants of the Brownian dumbbell step core.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POS_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOB_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOB_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 3'd6;

    // configuration reset values
    localparam logic [31:0] POS_LOW_RST  = 32'd0;
    localparam logic [31:0] POS_HIGH_RST = 32'd655360;
    localparam logic [30:0] MOB_LOW_RST  = 31'd6554;
    localparam logic [30:0] MOB_HIGH_RST = 31'd65536;
    localparam logic [30:0] REST_RST     = 31'd196608;
    localparam logic [31:0] TARGET_RST   = 32'd327680;
    localparam logic [16:0] GAIN_RST     = 17'd655;

    // bead reset positions, Q16.16
    localparam int BEAD_A_Y_RST = 131072;
    localparam int BEAD_B_Y_RST = 327680;

    // CORDIC gain correction, Q1.30
    localparam logic [30:0] KINV_Q30     = 31'd652032874;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] ANGLE_ROUND  = 32'h0000_8000;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_LOAD,
        OP_MOB,
        OP_MUL,
        OP_DIV,
        OP_ROT_KICK,
        OP_ROT_SPRING,
        OP_VEC_SPRING,
        OP_VEC_AXIS,
        OP_KICK_UPD,
        OP_SPRING_UPD,
        OP_HEIGHT_UPD,
        OP_ZERO_ANG,
        OP_OUT
    } t_op;

    // multiplier operand set, also fixes the destination and the shift
    typedef enum logic [2:0] {
        M_DIFF,
        M_MAG,
        M_KX,
        M_KY,
        M_DIST,
        M_MOVE,
        M_SHIFT
    } t_msel;

    typedef struct packed {
        t_op   op;
        t_msel msel;
        logic  bead;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic done;
        logic mob_simple;
        logic vec_zero;
    } t_status;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10680094;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41721;
            5'd15: v = 32'd20860;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2607;
            5'd19: v = 32'd1303;
            5'd20: v = 32'd651;
            5'd21: v = 32'd325;
            5'd22: v = 32'd162;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/bds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_ctrl
// Sequencer: walks one item through kick, spring, height and axis steps,
// issuing datapath commands and waiting on unit completion.
// ----------------------------------------------------------------------------
module bds_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  bds_pkg::t_status i_status,
    output bds_pkg::t_cmd  o_cmd
);
    import bds_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE  = 21'h000001,
        S_DISP  = 21'h000002,
        S_MOB   = 21'h000004,
        S_DIV   = 21'h000008,
        S_MAG   = 21'h000010,
        S_ROTK  = 21'h000020,
        S_KX    = 21'h000040,
        S_KY    = 21'h000080,
        S_KUPD  = 21'h000100,
        S_SCHK  = 21'h000200,
        S_DIST  = 21'h000400,
        S_MOVE  = 21'h000800,
        S_ROTS  = 21'h001000,
        S_UX    = 21'h002000,
        S_UY    = 21'h004000,
        S_SUPD  = 21'h008000,
        S_SHIFT = 21'h010000,
        S_HUPD  = 21'h020000,
        S_AXIS  = 21'h040000,
        S_OUT   = 21'h080000,
        S_WAIT  = 21'h100000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_bead, n_bead;
    logic   r_ovalid, n_ovalid;
    t_cmd   cmd;

    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_bead   = r_bead;
        n_ovalid = r_ovalid & ~i_out_ready;
        cmd      = '{op: OP_NONE, msel: M_DIFF, bead: r_bead};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_START;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_bead = 1'b0;
                if (i_status.kind) begin
                    cmd.op  = OP_LOAD;
                    n_state = S_AXIS;
                end else begin
                    n_state = S_MOB;
                end
            end
            S_MOB: begin
                if (i_status.mob_simple) begin
                    cmd.op  = OP_MOB;
                    n_state = S_MAG;
                end else begin
                    cmd.op   = OP_MUL;
                    cmd.msel = M_DIFF;
                    n_ret    = S_DIV;
                    n_state  = S_WAIT;
                end
            end
            S_DIV: begin
                cmd.op  = OP_DIV;
                n_ret   = S_MAG;
                n_state = S_WAIT;
            end
            S_MAG: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_MAG;
                n_ret    = S_ROTK;
                n_state  = S_WAIT;
            end
            S_ROTK: begin
                cmd.op  = OP_ROT_KICK;
                n_ret   = S_KX;
                n_state = S_WAIT;
            end
            S_KX: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_KX;
                n_ret    = S_KY;
                n_state  = S_WAIT;
            end
            S_KY: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_KY;
                n_ret    = S_KUPD;
                n_state  = S_WAIT;
            end
            S_KUPD: begin
                cmd.op = OP_KICK_UPD;
                if (!r_bead) begin
                    n_bead  = 1'b1;
                    n_state = S_MOB;
                end else begin
                    n_state = S_SCHK;
                end
            end
            S_SCHK: begin
                // coincident beads: no spring pull
                if (i_status.vec_zero) begin
                    n_state = S_SHIFT;
                end else begin
                    cmd.op  = OP_VEC_SPRING;
                    n_ret   = S_DIST;
                    n_state = S_WAIT;
                end
            end
            S_DIST: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_DIST;
                n_ret    = S_MOVE;
                n_state  = S_WAIT;
            end
            S_MOVE: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_MOVE;
                n_ret    = S_ROTS;
                n_state  = S_WAIT;
            end
            S_ROTS: begin
                cmd.op  = OP_ROT_SPRING;
                n_ret   = S_UX;
                n_state = S_WAIT;
            end
            S_UX: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_KX;
                n_ret    = S_UY;
                n_state  = S_WAIT;
            end
            S_UY: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_KY;
                n_ret    = S_SUPD;
                n_state  = S_WAIT;
            end
            S_SUPD: begin
                cmd.op  = OP_SPRING_UPD;
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                cmd.op   = OP_MUL;
                cmd.msel = M_SHIFT;
                n_ret    = S_HUPD;
                n_state  = S_WAIT;
            end
            S_HUPD: begin
                cmd.op  = OP_HEIGHT_UPD;
                n_state = S_AXIS;
            end
            S_AXIS: begin
                if (i_status.vec_zero) begin
                    cmd.op  = OP_ZERO_ANG;
                    n_state = S_OUT;
                end else begin
                    cmd.op  = OP_VEC_AXIS;
                    n_ret   = S_OUT;
                    n_state = S_WAIT;
                end
            end
            S_OUT: begin
                // hold until the previous result is taken
                if (!r_ovalid) begin
                    cmd.op   = OP_OUT;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_WAIT: begin
                if (i_status.done) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_bead   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_bead   <= n_bead;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_cmd       = cmd;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |-> !r_ovalid)
        else $error("result register written while a result is pending");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.done |-> (r_state == S_WAIT))
        else $error("unit completion outside of a wait");

    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

endmodule

/* rtl/bds_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_dp
// Datapath: bead state, configuration, split multiplier, restoring divider,
// shared CORDIC (rotation and vectoring) and result registers.
// ----------------------------------------------------------------------------
module bds_dp #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bds_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_kind,
    input  logic [15:0]                        i_rand_len_a,
    input  logic [15:0]                        i_rand_angle_a,
    input  logic [15:0]                        i_rand_len_b,
    input  logic [15:0]                        i_rand_angle_b,
    input  logic signed [31:0]                 i_load_ax,
    input  logic signed [31:0]                 i_load_ay,
    input  logic signed [31:0]                 i_load_bx,
    input  logic signed [31:0]                 i_load_by,
    input  bds_pkg::t_cmd                      i_cmd,
    output bds_pkg::t_status                   o_status,
    output logic signed [31:0]                 o_out_ax,
    output logic signed [31:0]                 o_out_ay,
    output logic signed [31:0]                 o_out_bx,
    output logic signed [31:0]                 o_out_by,
    output logic signed [15:0]                 o_axis_angle,
    output logic                               o_saturated
);
    import bds_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int XW  = ((W > 32) ? W : 32) + 4;
    localparam int AW  = XW + 1;
    localparam int PW  = AW + 31;
    localparam int CIW = $clog2(CORDIC_STEPS);

    function automatic logic signed [XW-1:0] ext_w(input logic [W-1:0] v);
        return {{(XW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [XW-1:0] ext_32(input logic [31:0] v);
        return {{(XW-32){v[31]}}, v};
    endfunction

    // clamp to the coordinate range, flag in the top bit
    function automatic logic [W:0] sat_f(input logic signed [XW-1:0] v);
        logic [W:0] res;
        if ((&v[XW-1:W-1]) || !(|v[XW-1:W-1])) res = {1'b0, v[W-1:0]};
        else if (v[XW-1])                      res = {2'b11, {(W-1){1'b0}}};
        else                                   res = {2'b10, {(W-1){1'b1}}};
        return res;
    endfunction

    // configuration
    logic [31:0] r_pos_low, r_pos_high, r_target;
    logic [30:0] r_mob_low, r_mob_high, r_rest;
    logic [16:0] r_gain;

    // item payload
    logic        r_kind;
    logic [15:0] r_rlen_a, r_rang_a, r_rlen_b, r_rang_b;
    logic [31:0] r_ld_ax, r_ld_ay, r_ld_bx, r_ld_by;

    // bead state
    logic [W-1:0] r_ax, r_ay, r_bx, r_by, n_ax, n_ay, n_bx, n_by;
    logic         r_sat, n_sat;

    // working registers
    logic signed [XW-1:0] r_t, r_dx, r_dy;
    logic [30:0]          r_mob;
    logic [31:0]          r_ang;
    logic                 r_done, n_done;

    // multiplier
    logic signed [AW-1:0] r_ma;
    logic [30:0]          r_mc;
    t_msel                r_msel;
    logic [1:0]           r_mph;
    logic                 r_mbusy;
    logic signed [PW-1:0] r_macc, r_mhi, r_prod;

    // divider
    logic [32:0] r_drem;
    logic [31:0] r_dq;
    logic [4:0]  r_dcnt;
    logic        r_dbusy;

    // CORDIC
    logic signed [XW-1:0] r_cx, r_cy;
    logic signed [33:0]   r_cz;
    logic [CIW-1:0]       r_ci;
    logic                 r_cbusy, r_cvec;
    logic [31:0]          r_base;

    // result registers
    logic [31:0] r_o_ax, r_o_ay, r_o_bx, r_o_by;
    logic [15:0] r_o_ang;
    logic        r_o_sat;

    // ---------------------------------------------------------------- mobility
    logic signed [XW-1:0] pl_x, ph_x, cur_y, yc, dy_pos;
    logic [32:0]          span;
    logic [30:0]          mob_diff;
    logic                 mob_rev, span_ok;

    assign pl_x     = ext_32(r_pos_low);
    assign ph_x     = ext_32(r_pos_high);
    assign span_ok  = (ph_x > pl_x);
    assign mob_rev  = (r_mob_high <= r_mob_low);
    assign span     = ph_x[32:0] - pl_x[32:0];
    assign mob_diff = r_mob_high - r_mob_low;
    assign cur_y    = i_cmd.bead ? ext_w(r_by) : ext_w(r_ay);
    assign yc       = (cur_y < pl_x) ? pl_x : ((cur_y > ph_x) ? ph_x : cur_y);
    assign dy_pos   = yc - pl_x;

    // ---------------------------------------------------------- mul operands
    logic signed [XW-1:0] mean;
    logic signed [AW-1:0] mul_a, move_a, shift_a;
    logic [30:0]          mul_c;
    logic [15:0]          rlen_sel, rang_sel;

    assign mean     = (ext_w(r_ay) + ext_w(r_by)) >>> 1;
    assign shift_a  = {mean[XW-1], mean} - {{(AW-32){r_target[31]}}, r_target};
    assign move_a   = {r_t[XW-1], r_t} - {{(AW-31){1'b0}}, r_rest};
    assign rlen_sel = i_cmd.bead ? r_rlen_b : r_rlen_a;
    assign rang_sel = i_cmd.bead ? r_rang_b : r_rang_a;

    always_comb begin
        mul_a = '0;
        mul_c = '0;
        case (i_cmd.msel)
            M_DIFF: begin
                mul_a = {dy_pos[XW-1], dy_pos};
                mul_c = mob_diff;
            end
            M_MAG: begin
                mul_a = {{(AW-31){1'b0}}, r_mob};
                mul_c = {15'd0, rlen_sel};
            end
            M_KX, M_DIST: begin
                mul_a = {r_cx[XW-1], r_cx};
                mul_c = KINV_Q30;
            end
            M_KY: begin
                mul_a = {r_cy[XW-1], r_cy};
                mul_c = KINV_Q30;
            end
            M_MOVE: begin
                mul_a = move_a;
                mul_c = {14'd0, r_gain};
            end
            M_SHIFT: begin
                mul_a = shift_a;
                mul_c = {14'd0, r_gain};
            end
            default: begin
                mul_a = '0;
                mul_c = '0;
            end
        endcase
    end

    logic signed [PW-1:0]   mul_sum, mul_res;
    logic signed [AW+16:0]  pp_lo, pp_hi;

    assign pp_lo   = r_ma * $signed({1'b0, r_mc[15:0]});
    assign pp_hi   = r_ma * $signed({1'b0, r_mc[30:16]});
    assign mul_sum = r_macc + (r_mhi <<< 16);

    always_comb begin
        case (r_msel) inside
            M_KX, M_KY, M_DIST:    mul_res = mul_sum >>> 30;
            M_MAG, M_MOVE, M_SHIFT: mul_res = mul_sum >>> 16;
            default:               mul_res = mul_sum;
        endcase
    end

    // ---------------------------------------------------------------- divider
    logic [32:0] div_rem2, div_rem_n;
    logic        div_qbit;

    assign div_rem2  = {r_drem[31:0], r_dq[31]};
    assign div_qbit  = (div_rem2 >= span);
    assign div_rem_n = div_qbit ? (div_rem2 - span) : div_rem2;

    // ----------------------------------------------------------------- CORDIC
    logic [31:0]          th_in, th_fix;
    logic signed [XW-1:0] r_in, r_fix, vx, vy, xs, ys, c_nx, c_ny;
    logic signed [33:0]   c_at, c_nz;
    logic                 th_flip, v_neg, c_pos;

    assign th_in   = (i_cmd.op == OP_ROT_KICK) ? {rang_sel, 16'd0} : r_ang;
    assign r_in    = r_t;
    assign th_flip = ((th_in + QUARTER_TURN) & HALF_TURN) != 32'd0;
    assign th_fix  = th_flip ? (th_in + HALF_TURN) : th_in;
    assign r_fix   = th_flip ? -r_in : r_in;

    assign vx    = (i_cmd.op == OP_VEC_SPRING) ? (ext_w(r_bx) - ext_w(r_ax))
                                               : (ext_w(r_ax) - ext_w(r_bx));
    assign vy    = (i_cmd.op == OP_VEC_SPRING) ? (ext_w(r_by) - ext_w(r_ay))
                                               : (ext_w(r_ay) - ext_w(r_by));
    assign v_neg = vx[XW-1];

    assign xs    = r_cx >>> r_ci;
    assign ys    = r_cy >>> r_ci;
    assign c_at  = {2'b00, atan_turn(5'(r_ci))};
    // rotate toward zero angle residue, or toward zero y when vectoring
    assign c_pos = r_cvec ? r_cy[XW-1] : ~r_cz[33];
    assign c_nx  = c_pos ? (r_cx - ys) : (r_cx + ys);
    assign c_ny  = c_pos ? (r_cy + xs) : (r_cy - xs);
    assign c_nz  = c_pos ? (r_cz - c_at) : (r_cz + c_at);

    // last cycle of any busy unit
    assign n_done = (r_mbusy && (r_mph == 2'd2))
                 || (r_dbusy && (r_dcnt == 5'd31))
                 || (r_cbusy && (r_ci == CIW'(CORDIC_STEPS - 1)));

    // -------------------------------------------------------- position update
    logic [W:0] k_x, k_y, sa_x, sa_y, sb_x, sb_y, h_a, h_b, l_ax, l_ay, l_bx, l_by;

    assign k_x  = sat_f((i_cmd.bead ? ext_w(r_bx) : ext_w(r_ax)) + r_dx);
    assign k_y  = sat_f((i_cmd.bead ? ext_w(r_by) : ext_w(r_ay)) + r_dy);
    assign sa_x = sat_f(ext_w(r_ax) + r_dx);
    assign sa_y = sat_f(ext_w(r_ay) + r_dy);
    assign sb_x = sat_f(ext_w(r_bx) - r_dx);
    assign sb_y = sat_f(ext_w(r_by) - r_dy);
    assign h_a  = sat_f(ext_w(r_ay) - r_dy);
    assign h_b  = sat_f(ext_w(r_by) - r_dy);
    assign l_ax = sat_f(ext_32(r_ld_ax));
    assign l_ay = sat_f(ext_32(r_ld_ay));
    assign l_bx = sat_f(ext_32(r_ld_bx));
    assign l_by = sat_f(ext_32(r_ld_by));

    always_comb begin
        n_ax  = r_ax;
        n_ay  = r_ay;
        n_bx  = r_bx;
        n_by  = r_by;
        n_sat = r_sat;
        case (i_cmd.op)
            OP_START: n_sat = 1'b0;
            OP_LOAD: begin
                n_ax  = l_ax[W-1:0];
                n_ay  = l_ay[W-1:0];
                n_bx  = l_bx[W-1:0];
                n_by  = l_by[W-1:0];
                n_sat = r_sat | l_ax[W] | l_ay[W] | l_bx[W] | l_by[W];
            end
            OP_KICK_UPD: begin
                if (i_cmd.bead) begin
                    n_bx = k_x[W-1:0];
                    n_by = k_y[W-1:0];
                end else begin
                    n_ax = k_x[W-1:0];
                    n_ay = k_y[W-1:0];
                end
                n_sat = r_sat | k_x[W] | k_y[W];
            end
            OP_SPRING_UPD: begin
                n_ax  = sa_x[W-1:0];
                n_ay  = sa_y[W-1:0];
                n_bx  = sb_x[W-1:0];
                n_by  = sb_y[W-1:0];
                n_sat = r_sat | sa_x[W] | sa_y[W] | sb_x[W] | sb_y[W];
            end
            OP_HEIGHT_UPD: begin
                n_ay  = h_a[W-1:0];
                n_by  = h_b[W-1:0];
                n_sat = r_sat | h_a[W] | h_b[W];
            end
            default: ;
        endcase
    end

    logic signed [XW-1:0] o_ax_x, o_ay_x, o_bx_x, o_by_x;
    logic [31:0]          ang_rnd;

    assign o_ax_x  = ext_w(r_ax);
    assign o_ay_x  = ext_w(r_ay);
    assign o_bx_x  = ext_w(r_bx);
    assign o_by_x  = ext_w(r_by);
    assign ang_rnd = r_ang + ANGLE_ROUND;

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_low  <= POS_LOW_RST;
            r_pos_high <= POS_HIGH_RST;
            r_mob_low  <= MOB_LOW_RST;
            r_mob_high <= MOB_HIGH_RST;
            r_rest     <= REST_RST;
            r_target   <= TARGET_RST;
            r_gain     <= GAIN_RST;
            r_ax       <= '0;
            r_ay       <= W'(BEAD_A_Y_RST);
            r_bx       <= '0;
            r_by       <= W'(BEAD_B_Y_RST);
            r_sat      <= 1'b0;
            r_done     <= 1'b0;
            r_mbusy    <= 1'b0;
            r_mph      <= '0;
            r_dbusy    <= 1'b0;
            r_dcnt     <= '0;
            r_cbusy    <= 1'b0;
            r_ci       <= '0;
        end else begin
            r_done <= n_done;
            r_ax   <= n_ax;
            r_ay   <= n_ay;
            r_bx   <= n_bx;
            r_by   <= n_by;
            r_sat  <= n_sat;

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_POS_LOW:  r_pos_low  <= i_cfg_data;
                    CFG_POS_HIGH: r_pos_high <= i_cfg_data;
                    CFG_MOB_LOW:  r_mob_low  <= i_cfg_data[30:0];
                    CFG_MOB_HIGH: r_mob_high <= i_cfg_data[30:0];
                    CFG_REST:     r_rest     <= i_cfg_data[30:0];
                    CFG_TARGET:   r_target   <= i_cfg_data;
                    CFG_GAIN:     r_gain     <= i_cfg_data[16:0];
                    default: ;
                endcase
            end

            case (i_cmd.op)
                OP_START: begin
                    r_kind   <= i_kind;
                    r_rlen_a <= i_rand_len_a;
                    r_rang_a <= i_rand_angle_a;
                    r_rlen_b <= i_rand_len_b;
                    r_rang_b <= i_rand_angle_b;
                    r_ld_ax  <= i_load_ax;
                    r_ld_ay  <= i_load_ay;
                    r_ld_bx  <= i_load_bx;
                    r_ld_by  <= i_load_by;
                end
                OP_MOB: r_mob <= mob_rev ? r_mob_high : r_mob_low;
                OP_MUL: begin
                    r_ma    <= mul_a;
                    r_mc    <= mul_c;
                    r_msel  <= i_cmd.msel;
                    r_mph   <= 2'd0;
                    r_mbusy <= 1'b1;
                end
                OP_DIV: begin
                    r_drem  <= {1'b0, r_prod[63:32]};
                    r_dq    <= r_prod[31:0];
                    r_dcnt  <= '0;
                    r_dbusy <= 1'b1;
                end
                OP_ROT_KICK, OP_ROT_SPRING: begin
                    r_cx    <= r_fix;
                    r_cy    <= '0;
                    r_cz    <= {{2{th_fix[31]}}, th_fix};
                    r_cvec  <= 1'b0;
                    r_ci    <= '0;
                    r_cbusy <= 1'b1;
                end
                OP_VEC_SPRING, OP_VEC_AXIS: begin
                    r_cx    <= v_neg ? -vx : vx;
                    r_cy    <= v_neg ? -vy : vy;
                    r_cz    <= '0;
                    r_base  <= v_neg ? HALF_TURN : 32'd0;
                    r_cvec  <= 1'b1;
                    r_ci    <= '0;
                    r_cbusy <= 1'b1;
                end
                OP_ZERO_ANG: r_ang <= '0;
                OP_OUT: begin
                    r_o_ax  <= o_ax_x[31:0];
                    r_o_ay  <= o_ay_x[31:0];
                    r_o_bx  <= o_bx_x[31:0];
                    r_o_by  <= o_by_x[31:0];
                    r_o_ang <= ang_rnd[31:16];
                    r_o_sat <= r_sat;
                end
                default: ;
            endcase

            // split multiply: low half, high half, then combine and shift
            if (r_mbusy) begin
                case (r_mph)
                    2'd0: begin
                        r_macc <= PW'(pp_lo);
                        r_mph  <= 2'd1;
                    end
                    2'd1: begin
                        r_mhi <= PW'(pp_hi);
                        r_mph <= 2'd2;
                    end
                    default: begin
                        r_mbusy <= 1'b0;
                        case (r_msel)
                            M_DIFF:          r_prod <= mul_res;
                            M_MAG, M_DIST, M_MOVE: r_t <= mul_res[XW-1:0];
                            M_KX:            r_dx <= mul_res[XW-1:0];
                            default:         r_dy <= mul_res[XW-1:0];
                        endcase
                    end
                endcase
            end

            if (r_dbusy) begin
                r_drem <= div_rem_n;
                r_dq   <= {r_dq[30:0], div_qbit};
                r_dcnt <= r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    r_dbusy <= 1'b0;
                    r_mob   <= r_mob_low + r_dq[29:0] * 31'd2 + {30'd0, div_qbit};
                end
            end

            if (r_cbusy) begin
                r_cx <= c_nx;
                r_cy <= c_ny;
                r_cz <= c_nz;
                r_ci <= r_ci + 1'b1;
                if (r_ci == CIW'(CORDIC_STEPS - 1)) begin
                    r_cbusy <= 1'b0;
                    if (r_cvec) r_ang <= r_base + c_nz[31:0];
                end
            end
        end
    end

    assign o_status = '{kind:       r_kind,
                        done:       r_done,
                        mob_simple: mob_rev || !span_ok,
                        vec_zero:   (r_ax == r_bx) && (r_ay == r_by)};

    assign o_out_ax     = r_o_ax;
    assign o_out_ay     = r_o_ay;
    assign o_out_bx     = r_o_bx;
    assign o_out_by     = r_o_by;
    assign o_axis_angle = r_o_ang;
    assign o_saturated  = r_o_sat;

endmodule

/* rtl/brownian_dumbbell_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brownian_dumbbell_step_core
// Two-bead Brownian dumbbell: random kicks with position-dependent mobility,
// bond spring and height restraint, with the bead axis angle reported.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_kind, rand fields, load fields
//  out       output     o_out_valid / i_out_ready positions, axis angle, saturated
//  cfg       input      i_cfg_wr_en               i_cfg_index, i_cfg_data
//
//  A step transaction runs two kicks, each with a mobility divide, and in all
//  thirteen split multiplies and five CORDIC passes, all through one sequencer.
//  A flat mobility skips the divide and its multiply in each kick; coincident
//  beads skip the spring. A load transaction runs at most the axis CORDIC pass.
//  One transaction is in work at a time; the next is taken while a result waits.
//  Reset is synchronous; no clearing pass. A stalled result holds the sequencer
//  in its output step until taken.
// ----------------------------------------------------------------------------
module brownian_dumbbell_step_core #(
    parameter int COORD_WIDTH  = 32,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [bds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [15:0]                    i_rand_len_a,
    input  logic [15:0]                    i_rand_angle_a,
    input  logic [15:0]                    i_rand_len_b,
    input  logic [15:0]                    i_rand_angle_b,
    input  logic signed [31:0]             i_load_ax,
    input  logic signed [31:0]             i_load_ay,
    input  logic signed [31:0]             i_load_bx,
    input  logic signed [31:0]             i_load_by,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_out_ax,
    output logic signed [31:0]             o_out_ay,
    output logic signed [31:0]             o_out_bx,
    output logic signed [31:0]             o_out_by,
    output logic signed [15:0]             o_axis_angle,
    output logic                           o_saturated
);
    import bds_pkg::*;

    t_cmd    cmd;
    t_status status;

    bds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bds_dp #(
        .COORD_WIDTH  (COORD_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_rand_len_a   (i_rand_len_a),
        .i_rand_angle_a (i_rand_angle_a),
        .i_rand_len_b   (i_rand_len_b),
        .i_rand_angle_b (i_rand_angle_b),
        .i_load_ax      (i_load_ax),
        .i_load_ay      (i_load_ay),
        .i_load_bx      (i_load_bx),
        .i_load_by      (i_load_by),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_ax       (o_out_ax),
        .o_out_ay       (o_out_ay),
        .o_out_bx       (o_out_bx),
        .o_out_by       (o_out_by),
        .o_axis_angle   (o_axis_angle),
        .o_saturated    (o_saturated)
    );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Brownian dumbbell step core. A driver feeds
// step and load transactions with random gaps. A bit-exact fixed-point model
// of the two beads predicts each result. A monitor compares every result, and
// random back-pressure is applied on the output. Several register settings
// are used, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
    import bds_pkg::*;

    localparam int  N_STEPS     = 16;
    localparam int  IDLE_LIMIT  = 20000;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    localparam longint ARCTAN_TURN [N_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680094, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41721, 20860
    };

    typedef struct {
        logic        kind;
        logic [15:0] len_a, ang_a, len_b, ang_b;
        logic [31:0] ax, ay, bx, by;
    } bead_txn_t;

    typedef struct {
        logic [31:0] ax, ay, bx, by;
        logic [15:0] axis;
        logic        clip;
    } bead_pos_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [15:0] len_a = '0, ang_a = '0, len_b = '0, ang_b = '0;
    logic signed [31:0] load_ax = '0, load_ay = '0, load_bx = '0, load_by = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic signed [31:0] out_ax, out_ay, out_bx, out_by;
    logic signed [15:0] axis_angle;
    logic        saturated;

    brownian_dumbbell_step_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_kind(kind), .i_rand_len_a(len_a), .i_rand_angle_a(ang_a),
        .i_rand_len_b(len_b), .i_rand_angle_b(ang_b),
        .i_load_ax(load_ax), .i_load_ay(load_ay),
        .i_load_bx(load_bx), .i_load_by(load_by),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_ax(out_ax), .o_out_ay(out_ay), .o_out_bx(out_bx), .o_out_by(out_by),
        .o_axis_angle(axis_angle), .o_saturated(saturated)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // model copy of the registers and the beads
    longint pos_low, pos_high, mob_low, mob_high, rest_len, target_y, gain;
    longint bead_ax, bead_ay, bead_bx, bead_by;
    bit     clip_hit;

    bead_txn_t pending_txns[$];
    bead_pos_t expected_pos[$];
    int  errors = 0;
    int  idle_cycles = 0;
    bit  in_fire = 1'b0;
    bit  no_idle = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) begin
            clip_hit = 1'b1;
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            clip_hit = 1'b1;
            return COORD_MIN;
        end
        return v;
    endfunction

    // floor(a * c / 2^s)
    function automatic longint mul_floor(longint a, longint c, int s);
        longint hi;
        longint unsigned lo;
        hi = a >>> s;
        lo = longint'(a) & ((64'd1 << s) - 1);
        return hi * c + longint'((lo * longint'(c)) >> s);
    endfunction

    task automatic cordic_rotate(input longint r, input logic [31:0] th,
                                 output longint ox, output longint oy);
        longint x, y, z, nx;
        logic [31:0] t;
        t = th;
        if (((t + QUARTER_TURN) & HALF_TURN) != 0) begin
            t = t + HALF_TURN;
            r = -r;
        end
        z = longint'($signed(t));
        x = r;
        y = 0;
        for (int i = 0; i < N_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ARCTAN_TURN[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ARCTAN_TURN[i];
            end
            x = nx;
        end
        ox = mul_floor(x, longint'(KINV_Q30), 30);
        oy = mul_floor(y, longint'(KINV_Q30), 30);
    endtask

    task automatic cordic_vector(input longint vx, input longint vy,
                                 output logic [31:0] ang, output longint mag);
        longint x, y, z, nx;
        logic [31:0] base;
        x = vx; y = vy; z = 0; base = '0;
        if (x < 0) begin
            x = -x; y = -y; base = HALF_TURN;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ARCTAN_TURN[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ARCTAN_TURN[i];
            end
            x = nx;
        end
        ang = base + z[31:0];
        mag = x;
    endtask

    function automatic longint mobility_at(longint y);
        longint span, yc;
        longint unsigned d, diff;
        span = pos_high - pos_low;
        if (mob_high <= mob_low) return mob_high;
        if (span <= 0) return mob_low;
        yc = y;
        if (yc < pos_low) yc = pos_low;
        if (yc > pos_high) yc = pos_high;
        d = longint'(yc - pos_low);
        diff = longint'(mob_high - mob_low);
        return mob_low + longint'((d * diff) / longint'(span));
    endfunction

    task automatic apply_kick(inout longint px, inout longint py,
                              input logic [15:0] rlen, input logic [15:0] rang);
        longint unsigned m;
        longint mag, dx, dy;
        m = longint'(mobility_at(py));
        mag = longint'((m * rlen) >> 16);
        cordic_rotate(mag, {rang, 16'h0000}, dx, dy);
        px = clamp_coord(px + dx);
        py = clamp_coord(py + dy);
    endtask

    task automatic advance_beads(input bead_txn_t t, output bead_pos_t p);
        longint vx, vy, k, bond_len, move, ux, uy, mean, shift;
        logic [31:0] ang, rnd;
        clip_hit = 1'b0;
        if (t.kind) begin
            bead_ax = clamp_coord(longint'($signed(t.ax)));
            bead_ay = clamp_coord(longint'($signed(t.ay)));
            bead_bx = clamp_coord(longint'($signed(t.bx)));
            bead_by = clamp_coord(longint'($signed(t.by)));
        end else begin
            apply_kick(bead_ax, bead_ay, t.len_a, t.ang_a);
            apply_kick(bead_bx, bead_by, t.len_b, t.ang_b);
            vx = bead_bx - bead_ax;
            vy = bead_by - bead_ay;
            // no pull when the beads coincide
            if (vx != 0 || vy != 0) begin
                cordic_vector(vx, vy, ang, k);
                bond_len = mul_floor(k, longint'(KINV_Q30), 30);
                move = mul_floor(bond_len - rest_len, gain, 16);
                cordic_rotate(move, ang, ux, uy);
                bead_ax = clamp_coord(bead_ax + ux);
                bead_ay = clamp_coord(bead_ay + uy);
                bead_bx = clamp_coord(bead_bx - ux);
                bead_by = clamp_coord(bead_by - uy);
            end
            mean = (bead_ay + bead_by) >>> 1;
            shift = mul_floor(mean - target_y, gain, 16);
            bead_ay = clamp_coord(bead_ay - shift);
            bead_by = clamp_coord(bead_by - shift);
        end
        p.axis = '0;
        vx = bead_ax - bead_bx;
        vy = bead_ay - bead_by;
        if (vx != 0 || vy != 0) begin
            cordic_vector(vx, vy, ang, k);
            rnd = ang + ANGLE_ROUND;
            p.axis = rnd[31:16];
        end
        p.ax = bead_ax[31:0];
        p.ay = bead_ay[31:0];
        p.bx = bead_bx[31:0];
        p.by = bead_by[31:0];
        p.clip = clip_hit;
    endtask

    function automatic int pick_gap();
        if (no_idle || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        bead_txn_t t;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_fire) begin
            // hold until accepted
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            in_valid <= 1'b0;
        end else if (pending_txns.size() > 0) begin
            t = pending_txns.pop_front();
            kind <= t.kind;
            len_a <= t.len_a; ang_a <= t.ang_a; len_b <= t.len_b; ang_b <= t.ang_b;
            load_ax <= t.ax; load_ay <= t.ay; load_bx <= t.bx; load_by <= t.by;
            in_valid <= 1'b1;
            gap_left = pick_gap();
        end else begin
            in_valid <= 1'b0;
        end

        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            out_ready <= 1'b1;
        end
    end

    // monitor: predict on input transactions, check on output transactions
    always @(posedge i_clk) begin
        bead_txn_t t;
        bead_pos_t p, e;
        in_fire <= in_valid && in_ready;
        if (i_rst_n) begin
            if (in_valid && in_ready) begin
                t.kind = kind;
                t.len_a = len_a; t.ang_a = ang_a; t.len_b = len_b; t.ang_b = ang_b;
                t.ax = load_ax; t.ay = load_ay; t.bx = load_bx; t.by = load_by;
                advance_beads(t, p);
                expected_pos.push_back(p);
            end
            if (out_valid && out_ready) begin
                if (expected_pos.size() == 0) begin
                    $display("%0t: unexpected result ax=%h", $realtime, out_ax);
                    errors++;
                end else begin
                    e = expected_pos.pop_front();
                    if (out_ax !== e.ax) begin
                        $display("%0t: out_ax exp %h got %h", $realtime, e.ax, out_ax);
                        errors++;
                    end
                    if (out_ay !== e.ay) begin
                        $display("%0t: out_ay exp %h got %h", $realtime, e.ay, out_ay);
                        errors++;
                    end
                    if (out_bx !== e.bx) begin
                        $display("%0t: out_bx exp %h got %h", $realtime, e.bx, out_bx);
                        errors++;
                    end
                    if (out_by !== e.by) begin
                        $display("%0t: out_by exp %h got %h", $realtime, e.by, out_by);
                        errors++;
                    end
                    if (axis_angle !== e.axis) begin
                        $display("%0t: axis_angle exp %h got %h", $realtime, e.axis,
                                 axis_angle);
                        errors++;
                    end
                    if (saturated !== e.clip) begin
                        $display("%0t: saturated exp %b got %b", $realtime, e.clip,
                                 saturated);
                        errors++;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            CFG_POS_LOW:  pos_low = longint'($signed(val));
            CFG_POS_HIGH: pos_high = longint'($signed(val));
            CFG_MOB_LOW:  mob_low = longint'(val[30:0]);
            CFG_MOB_HIGH: mob_high = longint'(val[30:0]);
            CFG_REST:     rest_len = longint'(val[30:0]);
            CFG_TARGET:   target_y = longint'($signed(val));
            CFG_GAIN:     gain = longint'(val[16:0]);
            default: ;
        endcase
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic drain();
        while (pending_txns.size() > 0 || in_valid || expected_pos.size() > 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 3000000)) - 32'd1500000;
            default: return 32'($urandom_range(0, 1000000));
        endcase
    endfunction

    function automatic bead_txn_t make_txn(logic k, logic [31:0] ax, logic [31:0] ay,
                                           logic [31:0] bx, logic [31:0] by);
        bead_txn_t t;
        t.kind = k;
        t.len_a = $urandom; t.ang_a = $urandom; t.len_b = $urandom; t.ang_b = $urandom;
        t.ax = ax; t.ay = ay; t.bx = bx; t.by = by;
        return t;
    endfunction

    task automatic queue_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 12)
                pending_txns.push_back(make_txn(1'b1, rand_coord(), rand_coord(),
                                                rand_coord(), rand_coord()));
            else
                pending_txns.push_back(make_txn(1'b0, $urandom, $urandom, $urandom,
                                                $urandom));
        end
    endtask

    initial begin
        bead_txn_t t;
        pos_low = longint'($signed(POS_LOW_RST));
        pos_high = longint'($signed(POS_HIGH_RST));
        mob_low = longint'(MOB_LOW_RST);
        mob_high = longint'(MOB_HIGH_RST);
        rest_len = longint'(REST_RST);
        target_y = longint'($signed(TARGET_RST));
        gain = longint'(GAIN_RST);
        bead_ax = 0; bead_ay = BEAD_A_Y_RST; bead_bx = 0; bead_by = BEAD_B_Y_RST;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: steps from reset with extreme random fractions
        t = make_txn(1'b0, 0, 0, 0, 0);
        t.len_a = 16'h0000; t.ang_a = 16'h0000; t.len_b = 16'h0000; t.ang_b = 16'h0000;
        pending_txns.push_back(t);
        t.len_a = 16'hFFFF; t.ang_a = 16'hFFFF; t.len_b = 16'hFFFF; t.ang_b = 16'hFFFF;
        pending_txns.push_back(t);
        t.ang_a = 16'h4000; t.ang_b = 16'hC000;
        pending_txns.push_back(t);
        t.ang_a = 16'h8000; t.ang_b = 16'h8000;
        pending_txns.push_back(t);
        // coincident beads, then a step from there
        pending_txns.push_back(make_txn(1'b1, 32'd65536, 32'd65536, 32'd65536, 32'd65536));
        t = make_txn(1'b0, 0, 0, 0, 0);
        t.len_a = 16'h0000; t.len_b = 16'h0000;
        pending_txns.push_back(t);
        // axis at pi: a to the left of b
        pending_txns.push_back(make_txn(1'b1, 32'd0, 32'd0, 32'd65536, 32'd0));
        // extreme loads and steps that push into saturation
        pending_txns.push_back(make_txn(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h80000000, 32'h80000000));
        t = make_txn(1'b0, 0, 0, 0, 0);
        t.len_a = 16'hFFFF; t.len_b = 16'hFFFF;
        pending_txns.push_back(t);
        pending_txns.push_back(make_txn(1'b1, 32'h80000000, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 32'h80000000));
        pending_txns.push_back(t);
        pending_txns.push_back(make_txn(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                        32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_txns.push_back(t);
        pending_txns.push_back(make_txn(1'b1, 32'hFFFFFFFF, 32'h00000001,
                                        32'h00000000, 32'hFFFFFFFE));
        pending_txns.push_back(t);
        drain();

        // reset settings
        queue_random(110);
        drain();

        // extremes of position span, mobility and target, unit gain, empty rest length
        write_reg(CFG_POS_LOW, 32'h80000000);
        write_reg(CFG_POS_HIGH, 32'h7FFFFFFF);
        write_reg(CFG_MOB_LOW, 32'd0);
        write_reg(CFG_MOB_HIGH, 32'h7FFFFFFF);
        write_reg(CFG_REST, 32'd0);
        write_reg(CFG_TARGET, 32'h80000000);
        write_reg(CFG_GAIN, 32'd65536);
        queue_random(90);
        drain();

        // gain above one, maximum rest length, highest target
        no_idle = 1'b1;
        write_reg(CFG_GAIN, 32'h0001FFFF);
        write_reg(CFG_REST, 32'h7FFFFFFF);
        write_reg(CFG_TARGET, 32'h7FFFFFFF);
        queue_random(80);
        drain();
        no_idle = 1'b0;

        // reversed mobility range
        write_reg(CFG_MOB_LOW, 32'd200000);
        write_reg(CFG_MOB_HIGH, 32'd100000);
        write_reg(CFG_GAIN, 32'd0);
        write_reg(CFG_REST, 32'd196608);
        write_reg(CFG_TARGET, 32'd0);
        queue_random(80);
        drain();

        // empty position span
        write_reg(CFG_MOB_LOW, 32'd30000);
        write_reg(CFG_MOB_HIGH, 32'd90000);
        write_reg(CFG_POS_LOW, 32'd655360);
        write_reg(CFG_POS_HIGH, 32'd655360);
        write_reg(CFG_GAIN, 32'd3000);
        queue_random(80);
        drain();

        // narrow span around the beads, random settings after that
        write_reg(CFG_POS_LOW, 32'd0);
        write_reg(CFG_POS_HIGH, 32'd1);
        write_reg(CFG_MOB_HIGH, 32'h7FFFFFFF);
        queue_random(80);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            write_reg(CFG_POS_LOW, 32'($urandom_range(0, 2000000)) - 32'd1000000);
            write_reg(CFG_POS_HIGH, 32'($urandom_range(0, 2000000)));
            write_reg(CFG_MOB_LOW, $urandom_range(0, 100000));
            write_reg(CFG_MOB_HIGH, $urandom_range(0, 300000));
            write_reg(CFG_REST, $urandom_range(0, 1000000));
            write_reg(CFG_TARGET, 32'($urandom_range(0, 2000000)) - 32'd1000000);
            write_reg(CFG_GAIN, $urandom_range(0, 131071));
            queue_random(95);
            drain();
        end

        // back to reset values
        write_reg(CFG_POS_LOW, POS_LOW_RST);
        write_reg(CFG_POS_HIGH, POS_HIGH_RST);
        write_reg(CFG_MOB_LOW, 32'(MOB_LOW_RST));
        write_reg(CFG_MOB_HIGH, 32'(MOB_HIGH_RST));
        write_reg(CFG_REST, 32'(REST_RST));
        write_reg(CFG_TARGET, TARGET_RST);
        write_reg(CFG_GAIN, 32'(GAIN_RST));
        queue_random(40);
        drain();

        repeat (300) @(posedge i_clk);
        if (errors == 0 && expected_pos.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
